// ----- rtl/btmx_pkg.sv -----
// Shared constants, codes and interface types of the binary trie max-XOR multiset.
`default_nettype none
package btmx_pkg;

    // Key width and node pool size.
    localparam int KEY_BITS  = 31;
    localparam int NODE_POOL = 65536;
    localparam int NODE_W    = $clog2(NODE_POOL);
    localparam int FREE_W    = NODE_W + 1;
    localparam int POS_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int CNT_W     = 32;
    localparam int TOTAL_W   = 32;
    localparam int LINK_W    = 2 * NODE_W;

    // Highest next-free index at which an insert still has KEY_BITS nodes available.
    localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(NODE_POOL - KEY_BITS);
    localparam logic [POS_W-1:0]  POS_TOP    = POS_W'(KEY_BITS - 1);

    // Operation codes.
    localparam logic [1:0] FN_INS = 2'd0;
    localparam logic [1:0] FN_DEL = 2'd1;
    localparam logic [1:0] FN_QRY = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // Source of the next node when the walk steps down one level.
    localparam logic [1:0] ADV_NX   = 2'd0;
    localparam logic [1:0] ADV_ALT  = 2'd1;
    localparam logic [1:0] ADV_LINK = 2'd2;

    // Input and result payloads.
    typedef struct packed {
        logic [1:0]          func;
        logic [KEY_BITS-1:0] key_value;
    } t_in;

    typedef struct packed {
        logic [KEY_BITS-1:0] max_xor;
        logic [1:0]          status;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       alloc;
        logic       link_clr;
        logic       cnt_rd;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       adv;
        logic [1:0] adv_src;
        logic       acc_set;
        logic       restart;
        logic       tot_inc;
        logic       tot_dec;
        logic       out_load;
        logic [1:0] out_st;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       link_none;
        logic       cnt_zero;
        logic       last;
        logic       ins_blocked;
        logic       set_empty;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/btmx_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none
module btmx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read of the same address per cycle; the read returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/btmx_ctrl.sv -----
// Controller state machine that sequences the trie walks.
`default_nettype none
module btmx_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire btmx_pkg::t_sts  i_sts,
    output btmx_pkg::t_cmd       o_cmd
);
    import btmx_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_L_RD   = 3'd2;
    localparam logic [2:0] S_L_WAIT = 3'd3;
    localparam logic [2:0] S_INIT   = 3'd4;
    localparam logic [2:0] S_C_WAIT = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_pass, n_pass;
    logic [1:0] r_res, n_res;

    // State, pass and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
            r_res   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_res   <= n_res;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_res   = r_res;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = 1'b0;
                    n_res      = ST_OK;
                    n_state    = S_START;
                end
            end
            S_START: begin
                case (i_sts.func)
                    FN_INS: begin
                        if (i_sts.ins_blocked) begin
                            n_res   = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_L_RD;
                        end
                    end
                    FN_DEL: begin
                        n_state = S_L_RD;
                    end
                    FN_QRY: begin
                        if (i_sts.set_empty) begin
                            n_res   = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_L_RD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_L_RD: begin
                // The link memory reads the current node in this cycle.
                n_state = S_L_WAIT;
            end
            S_L_WAIT: begin
                // Link pair of the current node is on the RAM output.
                case (i_sts.func)
                    FN_INS: begin
                        if (i_sts.link_none) begin
                            o_cmd.alloc = 1'b1;
                            n_state     = S_INIT;
                        end else begin
                            o_cmd.cnt_rd = 1'b1;
                            n_state      = S_C_WAIT;
                        end
                    end
                    FN_DEL: begin
                        if (i_sts.link_none && !r_pass) begin
                            n_res   = ST_ABSENT;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.cnt_rd = 1'b1;
                            n_state      = S_C_WAIT;
                        end
                    end
                    FN_QRY: begin
                        if (i_sts.link_none) begin
                            o_cmd.adv     = 1'b1;
                            o_cmd.adv_src = ADV_LINK;
                            n_state       = i_sts.last ? S_DONE : S_L_RD;
                        end else begin
                            o_cmd.cnt_rd = 1'b1;
                            n_state      = S_C_WAIT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INIT: begin
                // Clear the links of the freshly allocated node.
                o_cmd.link_clr = 1'b1;
                o_cmd.adv      = 1'b1;
                o_cmd.adv_src  = ADV_NX;
                if (i_sts.last) begin
                    o_cmd.tot_inc = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_L_RD;
                end
            end
            S_C_WAIT: begin
                // Count of the selected child is on the RAM output.
                case (i_sts.func)
                    FN_INS: begin
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.adv     = 1'b1;
                        o_cmd.adv_src = ADV_NX;
                        if (i_sts.last) begin
                            o_cmd.tot_inc = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            n_state = S_L_RD;
                        end
                    end
                    FN_DEL: begin
                        if (!r_pass) begin
                            if (i_sts.cnt_zero) begin
                                n_res   = ST_ABSENT;
                                n_state = S_DONE;
                            end else if (i_sts.last) begin
                                o_cmd.restart = 1'b1;
                                n_pass        = 1'b1;
                                n_state       = S_L_RD;
                            end else begin
                                o_cmd.adv     = 1'b1;
                                o_cmd.adv_src = ADV_NX;
                                n_state       = S_L_RD;
                            end
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                            o_cmd.adv     = 1'b1;
                            o_cmd.adv_src = ADV_NX;
                            if (i_sts.last) begin
                                o_cmd.tot_dec = 1'b1;
                                n_state       = S_DONE;
                            end else begin
                                n_state = S_L_RD;
                            end
                        end
                    end
                    FN_QRY: begin
                        o_cmd.adv = 1'b1;
                        if (i_sts.cnt_zero) begin
                            o_cmd.adv_src = ADV_ALT;
                        end else begin
                            o_cmd.adv_src = ADV_NX;
                            o_cmd.acc_set = 1'b1;
                        end
                        n_state = i_sts.last ? S_DONE : S_L_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_st   = r_res;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/btmx_dpath.sv -----
// Datapath: node memories, walk registers, totals and the result register.
`default_nettype none
module btmx_dpath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire btmx_pkg::t_cmd  i_cmd,
    output btmx_pkg::t_sts       o_sts,
    input  wire btmx_pkg::t_in   i_data,
    input  wire logic            i_out_ready,
    output logic                 o_valid,
    output btmx_pkg::t_out       o_data
);
    import btmx_pkg::*;

    logic [1:0]          r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_acc;
    logic [POS_W-1:0]    r_pos;
    logic [NODE_W-1:0]   r_cur;
    logic [NODE_W-1:0]   r_nx;
    logic [NODE_W-1:0]   r_alt;
    logic [FREE_W-1:0]   r_free;
    logic [TOTAL_W-1:0]  r_total;
    logic [1:0]          r_root_vld;
    logic                r_out_vld;
    t_out                r_out;

    logic [LINK_W-1:0]   w_lnk_rd;
    logic [LINK_W-1:0]   w_lnk_wd;
    logic [LINK_W-1:0]   w_new_pair;
    logic [NODE_W-1:0]   w_lnk_addr;
    logic                w_lnk_we;
    logic [CNT_W-1:0]    w_cnt_rd;
    logic [CNT_W-1:0]    w_cnt_wd;
    logic [NODE_W-1:0]   w_cnt_addr;
    logic                w_cnt_we;
    logic                w_bit;
    logic                w_at_root;
    logic [NODE_W-1:0]   w_zero;
    logic [NODE_W-1:0]   w_one;
    logic [NODE_W-1:0]   w_same;
    logic [NODE_W-1:0]   w_opp;
    logic [NODE_W-1:0]   w_sel;
    logic [NODE_W-1:0]   w_free_lo;
    logic [NODE_W-1:0]   w_adv;

    // Link pair of the current node; root links read as none until written.
    assign w_bit     = r_key[r_pos];
    assign w_at_root = (r_cur == '0);
    assign w_zero    = (w_at_root && !r_root_vld[0]) ? '0 : w_lnk_rd[NODE_W-1:0];
    assign w_one     = (w_at_root && !r_root_vld[1]) ? '0 : w_lnk_rd[LINK_W-1:NODE_W];
    assign w_same    = w_bit ? w_one : w_zero;
    assign w_opp     = w_bit ? w_zero : w_one;
    assign w_sel     = (r_func == FN_QRY) ? w_opp : w_same;
    assign w_free_lo = r_free[NODE_W-1:0];

    // Current node's links with the missing side pointed at the new node.
    assign w_new_pair = w_bit ? {w_free_lo, w_zero} : {w_one, w_free_lo};

    // Link memory port.
    assign w_lnk_we   = i_cmd.alloc | i_cmd.link_clr;
    assign w_lnk_addr = i_cmd.link_clr ? r_nx : r_cur;
    assign w_lnk_wd   = i_cmd.link_clr ? '0 : w_new_pair;

    // Count memory port.
    assign w_cnt_we = i_cmd.alloc | i_cmd.cnt_inc | i_cmd.cnt_dec;
    always_comb begin
        if (i_cmd.cnt_rd) begin
            w_cnt_addr = w_sel;
        end else if (i_cmd.alloc) begin
            w_cnt_addr = w_free_lo;
        end else begin
            w_cnt_addr = r_nx;
        end
        if (i_cmd.alloc) begin
            w_cnt_wd = CNT_W'(1);
        end else if (i_cmd.cnt_inc) begin
            w_cnt_wd = w_cnt_rd + CNT_W'(1);
        end else begin
            w_cnt_wd = w_cnt_rd - CNT_W'(1);
        end
    end

    btmx_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODE_POOL)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_lnk_we),
        .i_addr  (w_lnk_addr),
        .i_wdata (w_lnk_wd),
        .o_rdata (w_lnk_rd)
    );

    btmx_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NODE_POOL)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_addr  (w_cnt_addr),
        .i_wdata (w_cnt_wd),
        .o_rdata (w_cnt_rd)
    );

    // Node taken when the walk steps down one level.
    always_comb begin
        case (i_cmd.adv_src)
            ADV_ALT:  w_adv = r_alt;
            ADV_LINK: w_adv = w_same;
            default:  w_adv = r_nx;
        endcase
    end

    // Walk registers: operation, key, level, current node, query accumulator and the next and alternative children.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_data.func;
            r_key  <= i_data.key_value;
            r_acc  <= '0;
            r_pos  <= POS_TOP;
            r_cur  <= '0;
        end else if (i_cmd.restart) begin
            r_pos <= POS_TOP;
            r_cur <= '0;
        end else if (i_cmd.adv) begin
            r_cur <= w_adv;
            r_pos <= r_pos - POS_W'(1);
            if (i_cmd.acc_set) begin
                r_acc[r_pos] <= 1'b1;
            end
        end
        if (i_cmd.alloc) begin
            r_nx <= w_free_lo;
        end else if (i_cmd.cnt_rd) begin
            r_nx  <= w_sel;
            r_alt <= w_same;
        end
    end

    // Pool allocation, item total and root link validity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free     <= FREE_W'(1);
            r_total    <= '0;
            r_root_vld <= '0;
        end else begin
            if (i_cmd.alloc) begin
                r_free <= r_free + FREE_W'(1);
                if (w_at_root) begin
                    r_root_vld[w_bit] <= 1'b1;
                end
            end
            if (i_cmd.tot_inc) begin
                r_total <= r_total + TOTAL_W'(1);
            end else if (i_cmd.tot_dec) begin
                r_total <= r_total - TOTAL_W'(1);
            end
        end
    end

    // Result register; a waiting result does not block the next transfer in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.max_xor <= r_acc;
            r_out.status  <= i_cmd.out_st;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Status to the controller.
    assign o_sts.func        = r_func;
    assign o_sts.link_none   = (w_sel == '0);
    assign o_sts.cnt_zero    = (w_cnt_rd == '0);
    assign o_sts.last        = (r_pos == '0);
    assign o_sts.ins_blocked = (r_free > FREE_LIMIT) || (&r_total);
    assign o_sts.set_empty   = (r_total == '0);
    assign o_sts.out_free    = !r_out_vld || i_out_ready;

endmodule
`default_nettype wire

// ----- rtl/binary_trie_max_xor_multiset.sv -----
// Top level of the binary trie multiset with maximum-XOR query.
`default_nettype none
// Keeps a multiset of 31-bit values in a binary trie of 65536 nodes and
// answers, for a query key, the largest key XOR any stored value. One
// operation is in work at a time. Each trie level reads the single-port
// link memory and then the count memory, each with a registered read; a
// query level whose opposite child is missing skips the count read, and an
// insert level that allocates a new node writes the count instead. A delete
// walks the path twice, once to check presence and once to decrement, and
// stops early when the value turns out to be absent. A rejected insert, a
// query on an empty set and an unused code finish without walking the trie.
// The result sits in an output register, so the next item is taken while a
// finished result waits for its transfer.
// Nodes are never freed; software inserts any initial values after reset.
module binary_trie_max_xor_multiset (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire btmx_pkg::t_in   i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output btmx_pkg::t_out       o_data
);
    import btmx_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    btmx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Memories and walk registers.
    btmx_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_data      (i_data),
        .i_out_ready (i_ready),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire

// ----- tb/sv/btmx_trie_checker.sv -----
// Checker for the trie multiset: mirrors the trie, predicts every answer and compares.
`timescale 1ns / 1ps
module btmx_trie_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    input  logic           i_op_ready,
    input  btmx_pkg::t_in  i_op,
    input  logic           i_ans_valid,
    input  logic           i_ans_ready,
    input  btmx_pkg::t_out i_ans,
    output int             o_mismatches,
    output int             o_answers_due
);
    import btmx_pkg::*;

    // Mirror of the node pool, the allocation pointer and the stored value total.
    logic [NODE_W-1:0]  zero_link [NODE_POOL];
    logic [NODE_W-1:0]  one_link  [NODE_POOL];
    logic [CNT_W-1:0]   hits      [NODE_POOL];
    logic [FREE_W-1:0]  free_head;
    logic [TOTAL_W-1:0] stored;

    // Answers predicted for accepted operations, oldest first.
    t_out answers_due[$];
    int   misses = 0;

    function automatic logic [NODE_W-1:0] child(input logic [NODE_W-1:0] node,
                                                input logic bit_sel);
        return bit_sel ? one_link[node] : zero_link[node];
    endfunction

    // Add one copy of a value, growing the path where it is missing.
    function automatic logic [1:0] trie_insert(input logic [KEY_BITS-1:0] key);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] nxt;
        int pos;
        if (NODE_POOL - int'(free_head) < KEY_BITS || stored == '1) begin
            return ST_FULL;
        end
        node = '0;
        for (pos = KEY_BITS - 1; pos >= 0; pos--) begin
            nxt = child(node, key[pos]);
            if (nxt == '0) begin
                nxt = free_head[NODE_W-1:0];
                free_head++;
                if (key[pos]) begin
                    one_link[node] = nxt;
                end else begin
                    zero_link[node] = nxt;
                end
                zero_link[nxt] = '0;
                one_link[nxt]  = '0;
                hits[nxt]      = 1;
            end else begin
                hits[nxt]++;
            end
            node = nxt;
        end
        stored++;
        return ST_OK;
    endfunction

    // Remove one copy of a value; the whole path must be live before anything changes.
    function automatic logic [1:0] trie_delete(input logic [KEY_BITS-1:0] key);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] nxt;
        int pos;
        node = '0;
        for (pos = KEY_BITS - 1; pos >= 0; pos--) begin
            nxt = child(node, key[pos]);
            if (nxt == '0 || hits[nxt] == '0) begin
                return ST_ABSENT;
            end
            node = nxt;
        end
        node = '0;
        for (pos = KEY_BITS - 1; pos >= 0; pos--) begin
            node = child(node, key[pos]);
            hits[node]--;
        end
        stored--;
        return ST_OK;
    endfunction

    // Greedy walk toward the opposite bit gives the largest XOR with any stored value.
    function automatic t_out trie_best_xor(input logic [KEY_BITS-1:0] key);
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   alt;
        logic [KEY_BITS-1:0] best;
        int pos;
        if (stored == '0) begin
            return '{max_xor: '0, status: ST_EMPTY};
        end
        node = '0;
        best = '0;
        for (pos = KEY_BITS - 1; pos >= 0; pos--) begin
            alt = child(node, ~key[pos]);
            if (alt != '0 && hits[alt] != '0) begin
                node      = alt;
                best[pos] = 1'b1;
            end else begin
                node = child(node, key[pos]);
            end
        end
        return '{max_xor: best, status: ST_OK};
    endfunction

    function automatic t_out trie_answer(input t_in op);
        t_out ans;
        ans = '{max_xor: '0, status: ST_OK};
        case (op.func)
            FN_INS: ans.status = trie_insert(op.key_value);
            FN_DEL: ans.status = trie_delete(op.key_value);
            FN_QRY: ans = trie_best_xor(op.key_value);
            default: ans.status = ST_OK;
        endcase
        return ans;
    endfunction

    // Compare the result transfer first, then predict for an operation taken at the same edge.
    always @(posedge i_clk) begin : track
        t_out want;
        if (!i_rst_n) begin
            zero_link[0] = '0;
            one_link[0]  = '0;
            free_head    = FREE_W'(1);
            stored       = '0;
            answers_due.delete();
        end else begin
            if (i_ans_valid && i_ans_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result with none awaited: max_xor=%h status=%0d",
                             $time, i_ans.max_xor, i_ans.status);
                    misses++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_ans.max_xor !== want.max_xor) begin
                        $display("%0t: max_xor mismatch: expected %h, actual %h",
                                 $time, want.max_xor, i_ans.max_xor);
                        misses++;
                    end
                    if (i_ans.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_ans.status);
                        misses++;
                    end
                end
            end
            if (i_op_valid && i_op_ready) begin
                answers_due.push_back(trie_answer(i_op));
            end
        end
        o_mismatches  <= misses;
        o_answers_due <= answers_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: clock, reset, operation stimulus, result-side stalls and the verdict.
`timescale 1ns / 1ps
module tb_top;
    import btmx_pkg::*;

    localparam logic [1:0]          FN_SPARE     = 2'd3;
    localparam logic [KEY_BITS-1:0] KEY_MAX      = {KEY_BITS{1'b1}};
    localparam int                  RANDOM_OPS   = 700;
    localparam int                  FILL_OPS     = 150;
    localparam int                  LONG_HOLD    = 600;
    localparam int                  SETTLE       = 300;
    localparam int                  LIMIT_CYCLES = 5_000_000;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic dut_ready;
    logic res_valid;
    logic res_ready = 1'b0;
    t_out res_data;

    // Controls from the stimulus to the result side.
    logic long_hold_req = 1'b0;
    logic rx_quiet      = 1'b0;
    bit   tx_quiet      = 1'b0;

    int mismatches;
    int answers_due;

    binary_trie_max_xor_multiset dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (dut_ready),
        .i_data  (in_data),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_data  (res_data)
    );

    btmx_trie_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_op_valid    (in_valid),
        .i_op_ready    (dut_ready),
        .i_op          (in_data),
        .i_ans_valid   (res_valid),
        .i_ans_ready   (res_ready),
        .i_ans         (res_data),
        .o_mismatches  (mismatches),
        .o_answers_due (answers_due)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one operation, after an optional idle burst, and hold it until its transfer.
    task automatic push_op(input logic [1:0] fn, input logic [KEY_BITS-1:0] key);
        if (!tx_quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_data  <= '{func: fn, key_value: key};
        in_valid <= 1'b1;
        do @(posedge clk); while (!dut_ready);
    endtask

    // Stop offering and wait until every predicted answer has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (answers_due == 0);
        @(posedge clk);
    endtask

    // Mix of full-range values, clustered values and single-bit extremes.
    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [KEY_BITS-1:0] k;
        case ($urandom_range(0, 3))
            0, 1: k = KEY_BITS'($urandom());
            2: begin
                k      = KEY_BITS'($urandom_range(0, 3)) << 21;
                k[7:0] = 8'($urandom());
            end
            default: begin
                k = '0;
                k[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
                if ($urandom_range(0, 1) == 1) begin
                    k = ~k;
                end
                if ($urandom_range(0, 3) == 0) begin
                    k = ($urandom_range(0, 1) == 1) ? KEY_MAX : '0;
                end
            end
        endcase
        return k;
    endfunction

    // Bit-reversed index: consecutive indexes branch near the root, so each
    // insert grows a long fresh path and uses up many nodes.
    function automatic logic [KEY_BITS-1:0] spread_key(input int idx);
        logic [KEY_BITS-1:0] k;
        int b;
        for (b = 0; b < KEY_BITS; b++) begin
            k[KEY_BITS - 1 - b] = idx[b];
        end
        return k;
    endfunction

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : result_side
        int  stall_left;
        bit  hold_used;
        stall_left = 0;
        hold_used  = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req && !hold_used) begin
                hold_used = 1'b1;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (stall_left > 0 && !rx_quiet) begin
                stall_left--;
                res_ready <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total cycle count.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_BITS-1:0] live_keys[$];
        logic [KEY_BITS-1:0] key;
        int n;
        int roll;
        int idx;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty set, unused code, extremes, duplicates and absent values.
        push_op(FN_QRY, '0);
        push_op(FN_DEL, 31'h0123_4567);
        push_op(FN_SPARE, KEY_MAX);
        push_op(FN_INS, '0);
        push_op(FN_INS, KEY_MAX);
        push_op(FN_INS, KEY_MAX);
        push_op(FN_INS, 31'h5555_5555);
        push_op(FN_INS, 31'h2AAA_AAAA);
        push_op(FN_QRY, '0);
        push_op(FN_QRY, KEY_MAX);
        push_op(FN_QRY, 31'h2AAA_AAAA);
        push_op(FN_DEL, KEY_MAX);
        push_op(FN_QRY, '0);
        push_op(FN_DEL, KEY_MAX);
        push_op(FN_QRY, '0);
        // The path is still there but its counts are zero.
        push_op(FN_DEL, KEY_MAX);
        // Shares all but the last level with a stored value.
        push_op(FN_DEL, 31'h2AAA_AAAB);
        push_op(FN_SPARE, '0);
        push_op(FN_DEL, '0);
        push_op(FN_DEL, 31'h5555_5555);
        push_op(FN_DEL, 31'h2AAA_AAAA);
        // Nodes remain allocated, yet the set is empty.
        push_op(FN_QRY, 31'h5555_5555);
        push_op(FN_INS, 31'h0000_0001);
        push_op(FN_QRY, 31'h0000_0001);
        push_op(FN_QRY, 31'h4000_0000);
        live_keys.push_back(31'h0000_0001);

        // Random phase: mostly inserts and deletes of stored values, plus queries.
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n == 150) begin
                long_hold_req <= 1'b1;
            end
            if (n == 450) begin
                // Pause, then empty the set and check the empty answer.
                drain_results();
                while (live_keys.size() > 0) begin
                    push_op(FN_DEL, live_keys.pop_back());
                end
                push_op(FN_QRY, pick_key());
            end
            roll = $urandom_range(0, 99);
            if (roll < 38) begin
                key = pick_key();
                if (roll < 6 && live_keys.size() > 0) begin
                    key = live_keys[$urandom_range(0, live_keys.size() - 1)];
                end
                push_op(FN_INS, key);
                live_keys.push_back(key);
            end else if (roll < 62 && live_keys.size() > 0) begin
                idx = $urandom_range(0, live_keys.size() - 1);
                key = live_keys[idx];
                live_keys.delete(idx);
                push_op(FN_DEL, key);
            end else if (roll < 70) begin
                if (live_keys.size() > 0 && $urandom_range(0, 1) == 1) begin
                    key = live_keys[$urandom_range(0, live_keys.size() - 1)];
                    key[$urandom_range(0, KEY_BITS - 1)] ^= 1'b1;
                end else begin
                    key = KEY_BITS'($urandom());
                end
                push_op(FN_DEL, key);
            end else if (roll < 97) begin
                push_op(FN_QRY, pick_key());
            end else begin
                push_op(FN_SPARE, pick_key());
            end
        end

        // Last part, no idling: a run of inserts that each grow a long fresh path.
        drain_results();
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
        for (n = 0; n < FILL_OPS; n++) begin
            push_op(FN_INS, spread_key(n));
            if (n % 400 == 0) begin
                push_op(FN_QRY, KEY_BITS'($urandom()));
            end
        end
        push_op(FN_INS, spread_key(0));
        push_op(FN_INS, live_keys.size() > 0 ? live_keys[0] : KEY_MAX);
        push_op(FN_DEL, spread_key(1));
        push_op(FN_QRY, KEY_MAX);
        push_op(FN_DEL, spread_key(FILL_OPS - 1));
        push_op(FN_INS, spread_key(1));
        push_op(FN_QRY, '0);
        push_op(FN_SPARE, KEY_MAX);

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && answers_due == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/btmx_pkg.sv
rtl/btmx_ram.sv
rtl/btmx_ctrl.sv
rtl/btmx_dpath.sv
rtl/binary_trie_max_xor_multiset.sv
tb/sv/btmx_trie_checker.sv
tb/sv/tb_top.sv
